// ----- rtl/cfc_pkg.sv -----
`default_nettype none

package cfc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PLANE_WIDTH = 64;
   localparam int COORD_WIDTH = 24;
   localparam int PROD_WIDTH = 36;
   localparam int ADDEND_WIDTH = 38;
   localparam int SUM_WIDTH = 42;

   localparam logic [1:0] CMD_POINT = 2'd0;
   localparam logic [1:0] CMD_SPHERE = 2'd1;
   localparam logic [1:0] CMD_CUBE = 2'd2;
   localparam logic [1:0] CMD_BOX = 2'd3;

   localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [1:0] VERDICT_INSIDE = 2'd1;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

   typedef logic [PLANE_WIDTH-1:0] plane_word_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic signed [COORD_WIDTH-1:0] x_lo;
      logic signed [COORD_WIDTH-1:0] y_lo;
      logic signed [COORD_WIDTH-1:0] z_lo;
      logic signed [COORD_WIDTH-1:0] x_hi;
      logic signed [COORD_WIDTH-1:0] y_hi;
      logic signed [COORD_WIDTH-1:0] z_hi;
      logic [COORD_WIDTH-1:0] extent;
   } query_type;

   typedef struct packed {
      logic outside;
      logic below;
   } plane_flags_type;

endpackage

`default_nettype wire

// ----- rtl/cfc_csr.sv -----
`default_nettype none

module cfc_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [cfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [cfc_pkg::PLANE_WIDTH-1:0] csr_wdata,
   output cfc_pkg::plane_word_type [cfc_pkg::PLANE_COUNT-1:0] planes
);

   cfc_pkg::plane_word_type [cfc_pkg::PLANE_COUNT-1:0] planes_ff;
   cfc_pkg::plane_word_type [cfc_pkg::PLANE_COUNT-1:0] planes_in;

   assign csr_ready = 1'b1;
   assign planes = planes_ff;

   always_comb begin
      planes_in = planes_ff;
      for (int i = 0; i < cfc_pkg::PLANE_COUNT; i++) begin
         if (csr_valid && csr_index == cfc_pkg::CSR_INDEX_WIDTH'(i)) begin
            planes_in[i] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cfc_plane_unit.sv -----
`default_nettype none

module cfc_plane_unit (
   input wire logic clock,
   input wire logic load,
   input wire cfc_pkg::plane_word_type plane,
   input wire cfc_pkg::query_type query,
   output cfc_pkg::plane_flags_type flags
);

   localparam int PW = cfc_pkg::PROD_WIDTH;
   localparam int SW = cfc_pkg::SUM_WIDTH;
   localparam int AW = cfc_pkg::ADDEND_WIDTH;

   logic signed [11:0] a, b, c;
   logic signed [27:0] d;
   logic [11:0] abs_a, abs_b, abs_c;
   logic [12:0] abs_sum;
   logic [36:0] cube_term;
   logic signed [PW-1:0] p_xl, p_yl, p_zl, p_xh, p_yh, p_zh;
   logic min_lo_x, min_lo_y, min_lo_z;
   logic is_box;

   logic signed [PW-1:0] mx_in, my_in, mz_in, nx_in, ny_in, nz_in;
   logic [AW-1:0] addend_in;
   logic signed [PW-1:0] mx_ff, my_ff, mz_ff, nx_ff, ny_ff, nz_ff;
   logic [AW-1:0] addend_ff;
   logic signed [27:0] d_ff;
   logic box_ff;

   logic signed [SW-1:0] d_term, s_max, s_min;

   always_comb begin
      a = plane[11:0];
      b = plane[23:12];
      c = plane[35:24];
      d = plane[63:36];
      abs_a = a[11] ? 12'(-a) : 12'(a);
      abs_b = b[11] ? 12'(-b) : 12'(b);
      abs_c = c[11] ? 12'(-c) : 12'(c);
      abs_sum = 13'(abs_a) + 13'(abs_b) + 13'(abs_c);
      cube_term = 37'(query.extent) * 37'(abs_sum);

      p_xl = PW'(a) * PW'(query.x_lo);
      p_yl = PW'(b) * PW'(query.y_lo);
      p_zl = PW'(c) * PW'(query.z_lo);
      p_xh = PW'(a) * PW'(query.x_hi);
      p_yh = PW'(b) * PW'(query.y_hi);
      p_zh = PW'(c) * PW'(query.z_hi);

      min_lo_x = (query.x_lo <= query.x_hi) ^ a[11];
      min_lo_y = (query.y_lo <= query.y_hi) ^ b[11];
      min_lo_z = (query.z_lo <= query.z_hi) ^ c[11];
      is_box = (query.cmd == cfc_pkg::CMD_BOX);

      if (is_box) begin
         nx_in = min_lo_x ? p_xl : p_xh;
         ny_in = min_lo_y ? p_yl : p_yh;
         nz_in = min_lo_z ? p_zl : p_zh;
         mx_in = min_lo_x ? p_xh : p_xl;
         my_in = min_lo_y ? p_yh : p_yl;
         mz_in = min_lo_z ? p_zh : p_zl;
      end else begin
         nx_in = p_xl;
         ny_in = p_yl;
         nz_in = p_zl;
         mx_in = p_xl;
         my_in = p_yl;
         mz_in = p_zl;
      end

      case (query.cmd)
         cfc_pkg::CMD_SPHERE: begin
            addend_in = AW'({query.extent, 10'b0});
         end
         cfc_pkg::CMD_CUBE: begin
            addend_in = AW'(cube_term);
         end
         default: begin
            addend_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         mz_ff <= mz_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nz_ff <= nz_in;
         addend_ff <= addend_in;
         d_ff <= d;
         box_ff <= is_box;
      end
   end

   always_comb begin
      d_term = SW'($signed({d_ff, 10'b0}));
      s_max = SW'(mx_ff) + SW'(my_ff) + SW'(mz_ff) + d_term + SW'(addend_ff);
      s_min = SW'(nx_ff) + SW'(ny_ff) + SW'(nz_ff) + d_term;
      flags.outside = box_ff ? s_max[SW-1] : (s_max[SW-1] || s_max == '0);
      flags.below = box_ff && s_min[SW-1];
   end

endmodule

`default_nettype wire

// ----- rtl/frustum_cull_classifier.sv -----
// A query passes the query register, plane-unit registers and verdict register to rsp_.
// One query per cycle unless stalled; multiply stage, then six plane sums and compares.
// A stalled verdict holds; the input side keeps taking queries until both stages fill.
// Reset (synchronous, active high) empties the pipeline and clears all six planes to zero.
`default_nettype none

module frustum_cull_classifier (
   input wire logic clock,
   input wire logic reset,

   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_cmd,
   input wire logic signed [23:0] req_x_lo,
   input wire logic signed [23:0] req_y_lo,
   input wire logic signed [23:0] req_z_lo,
   input wire logic signed [23:0] req_x_hi,
   input wire logic signed [23:0] req_y_hi,
   input wire logic signed [23:0] req_z_hi,
   input wire logic [23:0] req_extent,

   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_verdict,

   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [cfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [cfc_pkg::PLANE_WIDTH-1:0] csr_wdata
);

   cfc_pkg::plane_word_type [cfc_pkg::PLANE_COUNT-1:0] planes;
   cfc_pkg::plane_flags_type [cfc_pkg::PLANE_COUNT-1:0] flags;
   logic [cfc_pkg::PLANE_COUNT-1:0] outside_vec, below_vec;

   cfc_pkg::query_type query_ff, query_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic [1:0] verdict_ff, verdict_in;
   logic out_ready, s2_ready, s1_ready;

   cfc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .planes(planes)
   );

   for (genvar g = 0; g < cfc_pkg::PLANE_COUNT; g++) begin : g_plane
      cfc_plane_unit u_plane (
         .clock(clock),
         .load(s2_ready),
         .plane(planes[g]),
         .query(query_ff),
         .flags(flags[g])
      );
      assign outside_vec[g] = flags[g].outside;
      assign below_vec[g] = flags[g].below;
   end

   always_comb begin
      out_ready = !out_valid_ff || !rsp_stall;
      s2_ready = !s2_valid_ff || out_ready;
      s1_ready = !s1_valid_ff || s2_ready;
      req_stall = !s1_ready;

      query_in.cmd = req_cmd;
      query_in.x_lo = req_x_lo;
      query_in.y_lo = req_y_lo;
      query_in.z_lo = req_z_lo;
      query_in.x_hi = req_x_hi;
      query_in.y_hi = req_y_hi;
      query_in.z_hi = req_z_hi;
      query_in.extent = req_extent;

      s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

      if (|outside_vec) begin
         verdict_in = cfc_pkg::VERDICT_OUTSIDE;
      end else if (|below_vec) begin
         verdict_in = cfc_pkg::VERDICT_INTERSECT;
      end else begin
         verdict_in = cfc_pkg::VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         query_ff <= query_in;
      end
      if (out_ready) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

`default_nettype wire

// ----- sim/tb_frustum_cull_classifier.sv -----
`default_nettype none

module tb_frustum_cull_classifier;

   localparam int PLANE_NEAR = 0;
   localparam int PLANE_FAR = 1;
   localparam int PLANE_LEFT = 2;
   localparam int PLANE_RIGHT = 3;
   localparam int PLANE_TOP = 4;
   localparam int PLANE_BOTTOM = 5;

   localparam int UNIT = 256;
   localparam int HALF_SPAN = 100 * UNIT;
   localparam int MIN_COORD = -8388608;
   localparam int MAX_COORD = 8388607;
   localparam int MAX_EXTENT = 16777215;
   localparam int ONE_NORMAL = 1024;
   localparam int ITEMS_PER_SETTING = 230;
   localparam int SETTING_COUNT = 8;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_cmd;
   logic signed [23:0] req_x_lo, req_y_lo, req_z_lo;
   logic signed [23:0] req_x_hi, req_y_hi, req_z_hi;
   logic [23:0] req_extent;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_verdict;
   logic csr_valid;
   logic csr_ready;
   logic [cfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [cfc_pkg::PLANE_WIDTH-1:0] csr_wdata;

   cfc_pkg::plane_word_type plane_words [cfc_pkg::PLANE_COUNT];
   cfc_pkg::plane_word_type staged_planes [cfc_pkg::PLANE_COUNT];
   logic [1:0] verdicts_due [$];
   bit idling_on = 1'b1;
   int hold_requests = 0;
   int holds_served = 0;
   int failures = 0;
   int queries_sent = 0;
   int verdicts_checked = 0;
   int settings_loaded = 0;
   int verdict_tally [3] = '{0, 0, 0};
   int cycle_count = 0;

   frustum_cull_classifier u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_x_lo(req_x_lo),
      .req_y_lo(req_y_lo),
      .req_z_lo(req_z_lo),
      .req_x_hi(req_x_hi),
      .req_y_hi(req_y_hi),
      .req_z_hi(req_z_hi),
      .req_extent(req_extent),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                verdicts_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic cfc_pkg::plane_word_type make_plane(input int a, input int b,
                                                          input int c, input int d);
      return {d[27:0], c[11:0], b[11:0], a[11:0]};
   endfunction

   function automatic longint plane_distance(input int p, input longint x, input longint y,
                                             input longint z);
      cfc_pkg::plane_word_type w;
      w = plane_words[p];
      return longint'($signed(w[11:0])) * x + longint'($signed(w[23:12])) * y
           + longint'($signed(w[35:24])) * z + longint'($signed(w[63:36])) * 1024;
   endfunction

   function automatic logic [1:0] classify(input cfc_pkg::query_type q);
      longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, radius, cx, cy, cz, dd;
      logic all_out, any_below;
      logic [1:0] verdict;
      lo_x = longint'($signed(q.x_lo));
      lo_y = longint'($signed(q.y_lo));
      lo_z = longint'($signed(q.z_lo));
      hi_x = longint'($signed(q.x_hi));
      hi_y = longint'($signed(q.y_hi));
      hi_z = longint'($signed(q.z_hi));
      radius = longint'(q.extent);
      verdict = cfc_pkg::VERDICT_INSIDE;
      any_below = 1'b0;
      for (int p = 0; p < cfc_pkg::PLANE_COUNT; p++) begin
         case (q.cmd)
            cfc_pkg::CMD_POINT: begin
               if (plane_distance(p, lo_x, lo_y, lo_z) <= 0)
                  verdict = cfc_pkg::VERDICT_OUTSIDE;
            end
            cfc_pkg::CMD_SPHERE: begin
               if (plane_distance(p, lo_x, lo_y, lo_z) <= -(radius * 1024))
                  verdict = cfc_pkg::VERDICT_OUTSIDE;
            end
            default: begin
               all_out = 1'b1;
               for (int k = 0; k < 8; k++) begin
                  if (q.cmd == cfc_pkg::CMD_CUBE) begin
                     cx = k[0] ? lo_x + radius : lo_x - radius;
                     cy = k[1] ? lo_y + radius : lo_y - radius;
                     cz = k[2] ? lo_z + radius : lo_z - radius;
                     dd = plane_distance(p, cx, cy, cz);
                     if (dd > 0) all_out = 1'b0;
                  end else begin
                     cx = k[0] ? hi_x : lo_x;
                     cy = k[1] ? hi_y : lo_y;
                     cz = k[2] ? hi_z : lo_z;
                     dd = plane_distance(p, cx, cy, cz);
                     if (dd >= 0) all_out = 1'b0;
                     else any_below = 1'b1;
                  end
               end
               if (all_out) verdict = cfc_pkg::VERDICT_OUTSIDE;
            end
         endcase
      end
      if (q.cmd == cfc_pkg::CMD_BOX && verdict != cfc_pkg::VERDICT_OUTSIDE && any_below)
         verdict = cfc_pkg::VERDICT_INTERSECT;
      return verdict;
   endfunction

   function automatic logic [23:0] rand_coord();
      int v;
      if ($urandom_range(0, 7) == 0) v = $urandom;
      else v = int'($urandom_range(0, 2097151)) - 1048576;
      return v[23:0];
   endfunction

   function automatic cfc_pkg::query_type rand_query();
      cfc_pkg::query_type q;
      q.cmd = 2'($urandom_range(cfc_pkg::CMD_POINT, cfc_pkg::CMD_BOX));
      q.x_lo = rand_coord();
      q.y_lo = rand_coord();
      q.z_lo = rand_coord();
      if (q.cmd == cfc_pkg::CMD_BOX && $urandom_range(0, 7) != 0) begin
         q.x_hi = q.x_lo + 24'($urandom_range(0, 1 << 19));
         q.y_hi = q.y_lo + 24'($urandom_range(0, 1 << 19));
         q.z_hi = q.z_lo + 24'($urandom_range(0, 1 << 19));
      end else begin
         q.x_hi = rand_coord();
         q.y_hi = rand_coord();
         q.z_hi = rand_coord();
      end
      if ($urandom_range(0, 7) == 0) q.extent = 24'($urandom);
      else q.extent = 24'($urandom_range(0, 1 << 19));
      return q;
   endfunction

   function automatic cfc_pkg::plane_word_type rand_plane();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      return make_plane(int'($urandom_range(0, 2048)) - 1024,
                        int'($urandom_range(0, 2048)) - 1024,
                        int'($urandom_range(0, 2048)) - 1024,
                        int'($urandom_range(0, 2359296)) - 262144);
   endfunction

   function automatic cfc_pkg::plane_word_type extreme_plane(input int i, input bit flip);
      return make_plane((i[0] ^ flip) ? -2048 : 2047, (i[1] ^ flip) ? -2048 : 2047,
                        (i[2] ^ flip) ? -2048 : 2047,
                        ((i < 3) ^ flip) ? 134217727 : -134217728);
   endfunction

   task automatic send_query(input cfc_pkg::query_type q);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= q.cmd;
      req_x_lo <= q.x_lo;
      req_y_lo <= q.y_lo;
      req_z_lo <= q.z_lo;
      req_x_hi <= q.x_hi;
      req_y_hi <= q.y_hi;
      req_z_hi <= q.z_hi;
      req_extent <= q.extent;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdicts_due.push_back(classify(q));
      queries_sent++;
   endtask

   task automatic send_shape(input logic [1:0] cmd, input int xl, input int yl, input int zl,
                             input int xh, input int yh, input int zh, input int ext);
      cfc_pkg::query_type q;
      q.cmd = cmd;
      q.x_lo = xl[23:0];
      q.y_lo = yl[23:0];
      q.z_lo = zl[23:0];
      q.x_hi = xh[23:0];
      q.y_hi = yh[23:0];
      q.z_hi = zh[23:0];
      q.extent = ext[23:0];
      send_query(q);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_planes();
      for (int i = PLANE_NEAR; i <= PLANE_BOTTOM; i++) begin
         csr_valid <= 1'b1;
         csr_index <= cfc_pkg::CSR_INDEX_WIDTH'(i);
         csr_wdata <= staged_planes[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         plane_words[i] = staged_planes[i];
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic test_zero_planes();
      send_shape(cfc_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_SPHERE, UNIT, -UNIT, 0, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_SPHERE, UNIT, -UNIT, 0, 0, 0, 0, 1);
      send_shape(cfc_pkg::CMD_CUBE, 0, 0, 0, 0, 0, 0, UNIT);
      send_shape(cfc_pkg::CMD_BOX, -UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, 0);
   endtask

   task automatic test_directed_shapes();
      wait_quiet();
      staged_planes[PLANE_NEAR] = make_plane(0, 0, ONE_NORMAL, HALF_SPAN);
      staged_planes[PLANE_FAR] = make_plane(0, 0, -ONE_NORMAL, HALF_SPAN);
      staged_planes[PLANE_LEFT] = make_plane(ONE_NORMAL, 0, 0, HALF_SPAN);
      staged_planes[PLANE_RIGHT] = make_plane(-ONE_NORMAL, 0, 0, HALF_SPAN);
      staged_planes[PLANE_TOP] = make_plane(0, -ONE_NORMAL, 0, HALF_SPAN);
      staged_planes[PLANE_BOTTOM] = make_plane(0, ONE_NORMAL, 0, HALF_SPAN);
      load_planes();
      send_shape(cfc_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_POINT, HALF_SPAN, 0, 0, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_POINT, HALF_SPAN - 1, 0, 0, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_SPHERE, 150 * UNIT, 0, 0, 0, 0, 0, 50 * UNIT);
      send_shape(cfc_pkg::CMD_SPHERE, 150 * UNIT, 0, 0, 0, 0, 0, 50 * UNIT + 1);
      send_shape(cfc_pkg::CMD_CUBE, 0, 0, 0, 0, 0, 0, HALF_SPAN);
      send_shape(cfc_pkg::CMD_CUBE, 200 * UNIT, 0, 0, 0, 0, 0, HALF_SPAN);
      send_shape(cfc_pkg::CMD_CUBE, MAX_COORD, MIN_COORD, MAX_COORD, 0, 0, 0, MAX_EXTENT);
      send_shape(cfc_pkg::CMD_BOX, -50 * UNIT, -50 * UNIT, -50 * UNIT, 50 * UNIT, 50 * UNIT,
                 50 * UNIT, 0);
      send_shape(cfc_pkg::CMD_BOX, -50 * UNIT, -50 * UNIT, -50 * UNIT, 150 * UNIT, 50 * UNIT,
                 50 * UNIT, 0);
      send_shape(cfc_pkg::CMD_BOX, 150 * UNIT, 0, 0, 250 * UNIT, 0, 0, 0);
      send_shape(cfc_pkg::CMD_BOX, HALF_SPAN, 0, 0, 200 * UNIT, 0, 0, 0);
      send_shape(cfc_pkg::CMD_BOX, 50 * UNIT, 50 * UNIT, 50 * UNIT, -50 * UNIT, -50 * UNIT,
                 -50 * UNIT, 0);
      send_shape(cfc_pkg::CMD_POINT, 0, 0, 0, MIN_COORD, MAX_COORD, MIN_COORD, MAX_EXTENT);
      send_shape(cfc_pkg::CMD_POINT, MIN_COORD, MIN_COORD, MIN_COORD, 0, 0, 0, 0);
      send_shape(cfc_pkg::CMD_BOX, MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD,
                 MAX_COORD, MAX_EXTENT);
      send_shape(cfc_pkg::CMD_SPHERE, MAX_COORD, MAX_COORD, MAX_COORD, 0, 0, 0, MAX_EXTENT);
   endtask

   task automatic test_extreme_planes();
      wait_quiet();
      for (int i = PLANE_NEAR; i <= PLANE_BOTTOM; i++) staged_planes[i] = extreme_plane(i, 1'b0);
      load_planes();
      send_shape(cfc_pkg::CMD_CUBE, MIN_COORD, MAX_COORD, MIN_COORD, 0, 0, 0, MAX_EXTENT);
      send_shape(cfc_pkg::CMD_BOX, MAX_COORD, MIN_COORD, MAX_COORD, MIN_COORD, MAX_COORD,
                 MIN_COORD, 0);
   endtask

   task automatic test_backpressure();
      hold_requests++;
      repeat (40) send_query(rand_query());
   endtask

   task automatic test_random_settings();
      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         idling_on = (setting < SETTING_COUNT - 2);
         wait_quiet();
         for (int i = PLANE_NEAR; i <= PLANE_BOTTOM; i++) begin
            if (setting == 0) staged_planes[i] = '0;
            else if (setting == 1) staged_planes[i] = extreme_plane(i, 1'b1);
            else staged_planes[i] = rand_plane();
         end
         load_planes();
         repeat (ITEMS_PER_SETTING) send_query(rand_query());
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $error("rsp_verdict: expected none, actual %0d", rsp_verdict);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (rsp_verdict !== want) begin
               $error("rsp_verdict: expected %0d, actual %0d", want, rsp_verdict);
               failures++;
            end else begin
               verdict_tally[want]++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= cfc_pkg::CMD_POINT;
      req_x_lo <= '0;
      req_y_lo <= '0;
      req_z_lo <= '0;
      req_x_hi <= '0;
      req_y_hi <= '0;
      req_z_hi <= '0;
      req_extent <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      for (int i = PLANE_NEAR; i <= PLANE_BOTTOM; i++) plane_words[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_zero_planes();
      test_directed_shapes();
      test_extreme_planes();
      test_backpressure();
      test_random_settings();
      wait_quiet();
      if (verdicts_due.size() != 0) begin
         $error("%0d expected verdicts never arrived", verdicts_due.size());
         failures++;
      end
      $display("Covered %0d queries and %0d verdicts over %0d plane settings",
               queries_sent, verdicts_checked, settings_loaded);
      $display("Verdicts seen: %0d outside, %0d inside, %0d intersecting; %0d long hold(s)",
               verdict_tally[cfc_pkg::VERDICT_OUTSIDE], verdict_tally[cfc_pkg::VERDICT_INSIDE],
               verdict_tally[cfc_pkg::VERDICT_INTERSECT], holds_served);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
